[hdl/assert_macros.svh]
// Assertion helpers shared by the deframer modules.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/wsd_pkg.sv]
`timescale 1ns / 1ps
package wsd_pkg;

  // Opcodes of interest in the first header byte.
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // Result kinds.
  localparam logic [1:0] ACT_TEXT  = 2'd0;
  localparam logic [1:0] ACT_PONG  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  // Short-length escape codes in the second header byte.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Result queue between parser and output stage.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // One classified result waiting for the output stage.
  typedef struct packed {
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic       has_data;
    logic [1:0] action;
    logic       fin_flag;
    logic       frame_last;
  } res_entry_t;

  // Queue status seen by the parser.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[hdl/wsd_front.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsd_front #(
  parameter int LENGTH_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  wsd_pkg::q_status_t  q_stat,
  output logic                push,
  output wsd_pkg::res_entry_t push_entry
);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]             phase_r, phase_nxt;
  logic [3:0]             hcnt_r, hcnt_nxt;
  logic                   fin_r, fin_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   masked_r, masked_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             pos_r, pos_nxt;
  logic                   closed_r, closed_nxt;

  logic                   accept;
  logic                   do_after;
  logic                   do_eoh;
  logic [LENGTH_BITS-1:0] len_val;
  logic [7:0]             key_byte;
  logic                   last;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    unique case (pos_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    rem_nxt    = rem_r;
    ovf_nxt    = ovf_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    closed_nxt = closed_r;
    do_after   = 1'b0;
    do_eoh     = 1'b0;
    len_val    = rem_r;
    last       = 1'b0;
    push       = 1'b0;
    push_entry = '0;
    push_entry.fin_flag = fin_r;

    if (accept && !closed_r) begin
      unique case (phase_r)
        PH_HDR1: begin
          masked_nxt = in_tdata[7];
          rem_nxt    = '0;
          ovf_nxt    = 1'b0;
          if (in_tdata[6:0] == wsd_pkg::LEN_EXT16 || in_tdata[6:0] == wsd_pkg::LEN_EXT64) begin
            hcnt_nxt  = (in_tdata[6:0] == wsd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
            phase_nxt = PH_EXTLEN;
          end else begin
            do_after = 1'b1;
            len_val  = LENGTH_BITS'(in_tdata[6:0]);
          end
        end
        PH_EXTLEN: begin
          // shift in big-endian; remember any bits pushed off the top
          ovf_nxt  = ovf_r | (|rem_r[LENGTH_BITS-1 -: 8]);
          rem_nxt  = {rem_r[LENGTH_BITS-9:0], in_tdata};
          hcnt_nxt = hcnt_r - 4'd1;
          if (hcnt_r == 4'd1) begin
            do_after = 1'b1;
            len_val  = ovf_nxt ? '1 : rem_nxt;
          end
        end
        PH_MASK: begin
          key_nxt  = {key_r[23:0], in_tdata};
          hcnt_nxt = hcnt_r - 4'd1;
          if (hcnt_r == 4'd1) begin
            do_eoh  = 1'b1;
            len_val = rem_r;
          end
        end
        PH_PAYLOAD: begin
          pos_nxt = pos_r + 2'd1;
          rem_nxt = rem_r - LENGTH_BITS'(1);
          last    = (rem_r == LENGTH_BITS'(1));
          if (last) begin
            phase_nxt = PH_HDR0;
          end
          push_entry.raw_byte   = in_tdata;
          push_entry.key_byte   = masked_r ? key_byte : 8'h00;
          push_entry.frame_last = last;
          if (opcode_r == wsd_pkg::OP_TEXT) begin
            push = 1'b1;
            push_entry.has_data = 1'b1;
            push_entry.action   = wsd_pkg::ACT_TEXT;
          end else if (opcode_r == wsd_pkg::OP_PING) begin
            push = 1'b1;
            push_entry.has_data = 1'b1;
            push_entry.action   = wsd_pkg::ACT_PONG;
          end else if (opcode_r == wsd_pkg::OP_CLOSE && last) begin
            push       = 1'b1;
            closed_nxt = 1'b1;
            push_entry = '0;
            push_entry.fin_flag   = fin_r;
            push_entry.action     = wsd_pkg::ACT_CLOSE;
            push_entry.frame_last = 1'b1;
          end
        end
        default: begin
          fin_nxt    = in_tdata[7];
          opcode_nxt = in_tdata[3:0];
          phase_nxt  = PH_HDR1;
        end
      endcase

      if (do_after) begin
        rem_nxt = len_val;
        if (masked_nxt) begin
          phase_nxt = PH_MASK;
          hcnt_nxt  = 4'd4;
          key_nxt   = '0;
        end else begin
          do_eoh = 1'b1;
        end
      end

      if (do_eoh) begin
        pos_nxt = 2'd0;
        if (len_val != '0) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          phase_nxt = PH_HDR0;
          push_entry.frame_last = 1'b1;
          if (opcode_r == wsd_pkg::OP_TEXT) begin
            push = 1'b1;
            push_entry.action = wsd_pkg::ACT_TEXT;
          end else if (opcode_r == wsd_pkg::OP_PING) begin
            push = 1'b1;
            push_entry.action = wsd_pkg::ACT_PONG;
          end else if (opcode_r == wsd_pkg::OP_CLOSE) begin
            push       = 1'b1;
            closed_nxt = 1'b1;
            push_entry.action = wsd_pkg::ACT_CLOSE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      hcnt_r   <= '0;
      fin_r    <= 1'b0;
      opcode_r <= '0;
      masked_r <= 1'b0;
      rem_r    <= '0;
      ovf_r    <= 1'b0;
      key_r    <= '0;
      pos_r    <= '0;
      closed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      rem_r    <= rem_nxt;
      ovf_r    <= ovf_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      closed_r <= closed_nxt;
    end
  end

  `ASSERT_CLK(a_closed_silent, !(closed_r && push), "result queued after close")
  `ASSERT_CLK(a_payload_nonzero, !(phase_r == PH_PAYLOAD && rem_r == '0), "payload phase with no bytes left")
  `ASSERT_NEXT(a_close_latches, push && push_entry.action == wsd_pkg::ACT_CLOSE, closed_r, "close not latched")

endmodule

[hdl/wsd_queue.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsd_pkg::res_entry_t push_entry,
  input  logic                pop,
  output wsd_pkg::q_status_t  q_stat,
  output wsd_pkg::res_entry_t head
);

  wsd_pkg::res_entry_t        mem_r [wsd_pkg::Q_DEPTH];
  logic [wsd_pkg::Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [wsd_pkg::Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [wsd_pkg::Q_AW:0]     count_r, count_nxt;
  logic                       do_push;
  logic                       do_pop;

  assign q_stat.full  = (count_r == (wsd_pkg::Q_AW+1)'(wsd_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + (wsd_pkg::Q_AW)'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + (wsd_pkg::Q_AW)'(1) : rd_ptr_r;
    count_nxt  = count_r + (wsd_pkg::Q_AW+1)'(do_push) - (wsd_pkg::Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ASSERT_CLK(a_no_overflow, !(push && q_stat.full), "push into full queue")
  `ASSERT_CLK(a_ptr_count, count_r[wsd_pkg::Q_AW-1:0] == (wr_ptr_r - rd_ptr_r), "ptr/count")

endmodule

[hdl/wsd_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wsd_pkg::q_status_t  q_stat,
  input  wsd_pkg::res_entry_t head,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic [3:0]          out_tuser,
  output logic                out_tlast
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;
  logic [3:0] user_r, user_nxt;
  logic       last_r, last_nxt;

  // refill the output register whenever it is empty or being taken
  assign pop = !q_stat.empty && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    last_nxt  = last_r;
    if (pop) begin
      valid_nxt = 1'b1;
      data_nxt  = head.has_data ? (head.raw_byte ^ head.key_byte) : 8'h00;
      user_nxt  = {head.fin_flag, head.action, head.has_data};
      last_nxt  = head.frame_last;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

  `ASSERT_CLK(a_empty_is_zero, !(valid_r && !user_r[0] && data_r != 8'h00), "data on a result without payload")

endmodule

[hdl/websocket_frame_deframer_top.sv]
`timescale 1ns / 1ps
// channel   | direction | tdata                | tuser                               | tlast
// ----------+-----------+----------------------+-------------------------------------+-----------
// in_       | in        | [7:0] in_byte        | -                                   | -
// out_      | out       | [7:0] data_byte      | [0] has_data [2:1] action [3] fin   | frame_last
//
// One byte is taken per cycle while the result queue has room; each result is
// registered in the queue and then in the output register. The queue sets the rate:
// in_tready drops only when the four-entry result queue is full behind a stalled output.
// rst_n is synchronous and clears the parser, queue pointers and output valid.
// After a close result every further byte is accepted and dropped until reset.
module websocket_frame_deframer_top #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic [3:0] out_tuser,  // [0] has_data, [2:1] action, [3] fin_flag
  output logic       out_tlast
);

  wsd_pkg::q_status_t  q_stat;
  wsd_pkg::res_entry_t push_entry;
  wsd_pkg::res_entry_t head;
  logic                push;
  logic                pop;

  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_entry(push_entry)
  );

  wsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .q_stat    (q_stat),
    .head      (head)
  );

  wsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

[tb/websocket_frame_deframer_top_test.sv]
`timescale 1ns / 1ps
module websocket_frame_deframer_top_test;

  localparam int LEN_BITS = 64;
  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LEN_BITS);
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_BYTES = 520;

  // Opcodes that the parser consumes without a result.
  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PONG_FRAME = 4'hA;

  // Length encodings in the second header byte.
  localparam int LEN_SHORT = 0;
  localparam int LEN_16 = 1;
  localparam int LEN_64 = 2;

  typedef enum logic [2:0] {P_HDR0, P_HDR1, P_EXTLEN, P_MASK, P_PAYLOAD} parse_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [1:0] action;
    logic       fin_flag;
    logic       frame_last;
  } ws_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic       out_tlast;

  websocket_frame_deframer_top #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  logic [7:0] frame_bytes_q[$];
  ws_result_t deframed_q[$];
  int bytes_planned = 0;
  int bytes_taken = 0;
  int mismatches = 0;
  int cycle_count = 0;
  logic in_fired = 1'b0;

  // Parser state mirrored from the accepted byte stream.
  parse_phase_t phase = P_HDR0;
  logic [3:0]  hdr_left = '0;
  logic        frame_fin = 1'b0;
  logic [3:0]  frame_op = '0;
  logic        frame_masked = 1'b0;
  logic [63:0] remain = '0;
  logic [31:0] mask_key = '0;
  logic [1:0]  key_pos = '0;
  logic        stream_closed = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic push_result(input logic [7:0] data, input logic has,
                             input logic [1:0] act, input logic is_last);
    ws_result_t r;
    r.data_byte = data;
    r.has_data = has;
    r.action = act;
    r.fin_flag = frame_fin;
    r.frame_last = is_last;
    deframed_q.push_back(r);
  endtask

  task automatic close_header();
    key_pos = '0;
    if (remain != 0) begin
      phase = P_PAYLOAD;
    end else begin
      phase = P_HDR0;
      if (frame_op == wsd_pkg::OP_TEXT) push_result(8'h00, 1'b0, wsd_pkg::ACT_TEXT, 1'b1);
      else if (frame_op == wsd_pkg::OP_PING) push_result(8'h00, 1'b0, wsd_pkg::ACT_PONG, 1'b1);
      else if (frame_op == wsd_pkg::OP_CLOSE) begin
        stream_closed = 1'b1;
        push_result(8'h00, 1'b0, wsd_pkg::ACT_CLOSE, 1'b1);
      end
    end
  endtask

  task automatic length_done();
    if (remain > LEN_MAX) remain = LEN_MAX;
    if (frame_masked) begin
      phase = P_MASK;
      hdr_left = 4'd4;
      mask_key = '0;
    end else begin
      close_header();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] data;
    logic       is_last;
    if (stream_closed) return;
    case (phase)
      P_HDR1: begin
        frame_masked = b[7];
        remain = '0;
        if (b[6:0] == wsd_pkg::LEN_EXT16 || b[6:0] == wsd_pkg::LEN_EXT64) begin
          hdr_left = (b[6:0] == wsd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
          phase = P_EXTLEN;
        end else begin
          remain = 64'(b[6:0]);
          length_done();
        end
      end
      P_EXTLEN: begin
        remain = {remain[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) length_done();
      end
      P_MASK: begin
        mask_key = {mask_key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) close_header();
      end
      P_PAYLOAD: begin
        data = b;
        if (frame_masked) data = b ^ mask_key[8 * (3 - int'(key_pos)) +: 8];
        key_pos = key_pos + 2'd1;
        remain = remain - 64'd1;
        is_last = (remain == 0);
        if (is_last) phase = P_HDR0;
        if (frame_op == wsd_pkg::OP_TEXT)
          push_result(data, 1'b1, wsd_pkg::ACT_TEXT, is_last);
        else if (frame_op == wsd_pkg::OP_PING)
          push_result(data, 1'b1, wsd_pkg::ACT_PONG, is_last);
        else if (frame_op == wsd_pkg::OP_CLOSE && is_last) begin
          stream_closed = 1'b1;
          push_result(8'h00, 1'b0, wsd_pkg::ACT_CLOSE, 1'b1);
        end
      end
      default: begin
        frame_fin = b[7];
        frame_op = b[3:0];
        phase = P_HDR1;
      end
    endcase
  endtask

  task automatic plan_byte(input logic [7:0] b);
    frame_bytes_q.push_back(b);
    bytes_planned++;
  endtask

  // fill: 0 random payload, 1 alternating 0x00 / 0xFF
  task automatic queue_frame(input logic fin, input logic [3:0] op, input logic masked,
                             input int unsigned len, input int len_form, input int fill);
    logic [31:0] key;
    logic [6:0]  len7;
    key = $urandom;
    plan_byte({fin, 3'($urandom_range(0, 7)), op});
    case (len_form)
      LEN_SHORT: len7 = 7'(len);
      LEN_16: len7 = wsd_pkg::LEN_EXT16;
      default: len7 = wsd_pkg::LEN_EXT64;
    endcase
    plan_byte({masked, len7});
    if (len_form == LEN_16) begin
      plan_byte(len[15:8]);
      plan_byte(len[7:0]);
    end else if (len_form == LEN_64) begin
      for (int i = 7; i >= 0; i--) plan_byte(8'(64'(len) >> (8 * i)));
    end
    if (masked) for (int i = 3; i >= 0; i--) plan_byte(key[8 * i +: 8]);
    for (int i = 0; i < int'(len); i++)
      plan_byte(fill != 0 ? (i % 2 == 1 ? 8'hFF : 8'h00) : 8'($urandom));
  endtask

  // Accept side: predict on each input transaction, check each output transaction.
  always @(posedge clk) begin
    ws_result_t got;
    ws_result_t want;
    in_fired <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tuser[0], out_tuser[2:1], out_tuser[3], out_tlast};
        if (deframed_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result data=%h has=%b act=%0d fin=%b last=%b",
                                  got.data_byte, got.has_data, got.action, got.fin_flag,
                                  got.frame_last));
        end else begin
          want = deframed_q.pop_front();
          if (got !== want)
            note_mismatch($sformatf(
              "exp data=%h has=%b act=%0d fin=%b last=%b, got data=%h has=%b act=%0d fin=%b last=%b",
              want.data_byte, want.has_data, want.action, want.fin_flag, want.frame_last,
              got.data_byte, got.has_data, got.action, got.fin_flag, got.frame_last));
        end
      end
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
        void'(frame_bytes_q.pop_front());
        bytes_taken++;
      end
    end
  end

  // Sender: bursts of random length with random gaps; hold a byte until it is taken.
  int burst_left = 16;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fired) begin
      if (gap_left > 0 || frame_bytes_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= frame_bytes_q[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: stall pattern that steps through four modes, plus one long hold-off.
  int rx_cycle = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && bytes_taken >= HOLD_AT) begin
        out_tready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        case ((rx_cycle / 64) % 4)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (rx_cycle % 8 != 7);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int r;
    int form;
    int unsigned len;
    logic [3:0] op;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty frames, masked and plain payloads, every length encoding, ignored opcodes.
    queue_frame(1'b1, wsd_pkg::OP_TEXT, 1'b0, 0, LEN_SHORT, 0);
    queue_frame(1'b0, wsd_pkg::OP_PING, 1'b1, 0, LEN_SHORT, 0);
    queue_frame(1'b1, wsd_pkg::OP_TEXT, 1'b1, 5, LEN_SHORT, 0);
    queue_frame(1'b0, wsd_pkg::OP_PING, 1'b0, 3, LEN_SHORT, 0);
    queue_frame(1'b1, OP_BINARY, 1'b1, 4, LEN_SHORT, 0);
    queue_frame(1'b1, OP_PONG_FRAME, 1'b0, 0, LEN_SHORT, 0);
    queue_frame(1'b0, wsd_pkg::OP_TEXT, 1'b1, 7, LEN_16, 0);
    queue_frame(1'b1, wsd_pkg::OP_PING, 1'b0, 2, LEN_64, 0);
    queue_frame(1'b1, wsd_pkg::OP_TEXT, 1'b0, 4, LEN_SHORT, 1);
    queue_frame(1'b1, wsd_pkg::OP_TEXT, 1'b1, 0, LEN_64, 0);
    queue_frame(1'b0, OP_CONT, 1'b1, 0, LEN_16, 0);

    // Pause the sender until every result of the directed frames is in.
    while (frame_bytes_q.size() != 0 || deframed_q.size() != 0) @(posedge clk);

    bytes_planned = 0;
    while (bytes_planned < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = wsd_pkg::OP_TEXT;
      else if (r < 65) op = wsd_pkg::OP_PING;
      else begin
        op = 4'($urandom_range(0, 15));
        while (op == wsd_pkg::OP_CLOSE || op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_PING)
          op = 4'($urandom_range(0, 15));
      end
      r = $urandom_range(0, 99);
      if (r < 80) begin
        form = LEN_SHORT;
        len = ($urandom_range(0, 19) == 0) ? 125 : $urandom_range(0, 12);
      end else begin
        form = (r < 92) ? LEN_16 : LEN_64;
        len = $urandom_range(0, 40);
      end
      queue_frame(1'($urandom_range(0, 1)), op, ($urandom_range(0, 9) < 7), len, form, 0);
    end

    // Close frame with a payload, then bytes that must all be dropped.
    queue_frame(1'b1, wsd_pkg::OP_CLOSE, 1'b1, 6, LEN_16, 0);
    queue_frame(1'b1, wsd_pkg::OP_TEXT, 1'b0, 3, LEN_SHORT, 0);
    queue_frame(1'b1, wsd_pkg::OP_PING, 1'b0, 0, LEN_SHORT, 0);

    while (frame_bytes_q.size() != 0 || deframed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (deframed_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", deframed_q.size()));
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
